FILE: src/imq_pkg.sv
// shared types, widths and codes for the indexed min priority queue
package imq_pkg;

    localparam int KEY_W        = 16;
    localparam int HANDLE_W     = 7;
    localparam int HANDLES      = 1 << HANDLE_W;
    localparam int COUNT_OUT_W  = 8;
    localparam int STATUS_W     = 2;
    localparam int DEF_CAPACITY = 128;

    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_REMOVE = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_DUP    = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // one stored entry of the sorted chain
    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    // operation broadcast to every cell
    typedef struct packed {
        logic                ins;
        logic                rem;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_cell_cmd;

endpackage

FILE: src/indexed_min_priority_queue_core.sv
// indexed min priority queue: key table, presence bits and a sorted chain of cells
// the result strobe o_done is registered from S_EXEC, the state entered on accept
// busy is high for the cycle after accept, in S_EXEC, so a new item is taken only once
//   the last is done; S_EXEC uses the registered key table read that precedes the chain update
// reset: synchronous, active low; clears the chain, presence bits and count
//   at once; the key table is not cleared and needs no clearing pass
// results are strobed for one cycle; the receiver cannot stall
module indexed_min_priority_queue_core
    import imq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_func,
    input  logic [KEY_W-1:0]       i_entry_key,
    input  logic [HANDLE_W-1:0]    i_entry_handle,
    output logic                   o_done,
    output logic [KEY_W-1:0]       o_min_key,
    output logic [COUNT_OUT_W-1:0] o_entry_count,
    output logic                   o_is_empty,
    output logic [STATUS_W-1:0]    o_status
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_state              r_state;
    t_state              n_state;
    logic                r_func;
    logic [KEY_W-1:0]    r_key;
    logic [HANDLE_W-1:0] r_handle;
    logic [KEY_W-1:0]    r_rd_key;
    logic [KEY_W-1:0]    r_key_mem [HANDLES];
    logic [HANDLES-1:0]  r_present;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_done;
    t_status             r_status;
    t_status             n_status;
    logic                w_accept;
    logic                w_ins;
    logic                w_rem;
    t_cell_cmd           w_cmd;
    t_entry              w_ent [CAPACITY];
    logic                w_lt  [CAPACITY];

    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        busy     = 1'b0;
        n_status = ST_OK;
        w_ins    = 1'b0;
        w_rem    = 1'b0;
        n_count  = r_count;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                busy    = 1'b1;
                n_state = S_IDLE;
                if (r_func == FN_INSERT) begin
                    if (r_count == CW'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else if (r_present[r_handle]) begin
                        n_status = ST_DUP;
                    end else begin
                        w_ins   = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    if (!r_present[r_handle]) begin
                        n_status = ST_ABSENT;
                    end else begin
                        w_rem   = 1'b1;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // item capture and key table
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func   <= i_func;
            r_key    <= i_entry_key;
            r_handle <= i_entry_handle;
            r_rd_key <= r_key_mem[i_entry_handle];
        end
        if (w_ins) begin
            r_key_mem[r_handle] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_count   <= '0;
            r_done    <= 1'b0;
            r_status  <= ST_OK;
        end else begin
            if (w_ins) begin
                r_present[r_handle] <= 1'b1;
            end else if (w_rem) begin
                r_present[r_handle] <= 1'b0;
            end
            r_count <= n_count;
            r_done  <= (r_state == S_EXEC);
            if (r_state == S_EXEC) begin
                r_status <= n_status;
            end
        end
    end

    // remove locates the entry by its stored key and handle
    assign w_cmd.ins    = w_ins;
    assign w_cmd.rem    = w_rem;
    assign w_cmd.key    = (r_func == FN_INSERT) ? r_key : r_rd_key;
    assign w_cmd.handle = r_handle;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        logic   w_left_lt;
        t_entry w_right;

        if (g == 0) begin : g_head
            assign w_left    = '0;
            assign w_left_lt = 1'b0;
        end else begin : g_mid
            assign w_left    = w_ent[g-1];
            assign w_left_lt = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_ent[g+1];
        end

        imq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_left    (w_left),
            .i_left_lt (w_left_lt),
            .i_right   (w_right),
            .o_ent     (w_ent[g]),
            .o_lt      (w_lt[g])
        );
    end

    assign o_done        = r_done;
    assign o_min_key     = w_ent[0].valid ? w_ent[0].key : '0;
    assign o_entry_count = COUNT_OUT_W'(r_count);
    assign o_is_empty    = (r_count == '0);
    assign o_status      = r_status;

endmodule

FILE: src/imq_cell.sv
// one cell of the sorted entry chain: holds an entry, shifts right on insert, left on remove
module imq_cell
    import imq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_entry    i_left,
    input  logic      i_left_lt,
    input  t_entry    i_right,
    output t_entry    o_ent,
    output logic      o_lt
);

    t_entry r_ent;
    t_entry n_ent;
    logic   w_ge;

    // entries are ordered by key, then handle; the core lets each handle in only once, so every stored pair is unique
    assign o_lt = !r_ent.valid ||
                  ({i_cmd.key, i_cmd.handle} < {r_ent.key, r_ent.handle});
    assign w_ge = r_ent.valid &&
                  ({r_ent.key, r_ent.handle} >= {i_cmd.key, i_cmd.handle});
    assign o_ent = r_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_cmd.ins) begin
            if (i_left_lt) begin
                n_ent = i_left;
            end else if (o_lt) begin
                n_ent.valid  = 1'b1;
                n_ent.key    = i_cmd.key;
                n_ent.handle = i_cmd.handle;
            end
        end else if (i_cmd.rem && w_ge) begin
            n_ent = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent <= n_ent;
        end
    end

endmodule
